[rtl/hsl2rgb_pkg.sv]
package hsl2rgb_pkg;

  localparam int unsigned FRAC_BITS = 12;

  localparam int unsigned HUE_W  = 11;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned FRAC_W = 9;
  localparam int unsigned LANES  = 3;

  localparam logic [HUE_W-1:0]  HUE_SIXTH      = 11'd256;
  localparam logic [HUE_W-1:0]  HUE_THIRD      = 11'd512;
  localparam logic [HUE_W-1:0]  HUE_HALF       = 11'd768;
  localparam logic [HUE_W-1:0]  HUE_TWO_THIRDS = 11'd1024;
  localparam logic [HUE_W-1:0]  HUE_TURN       = 11'd1536;
  localparam logic [FRAC_W-1:0] FRAC_FULL      = 9'd256;

  // bring a hue position below one full turn with one subtract
  function automatic logic [HUE_W-1:0] wrap_hue(input logic [HUE_W:0] t);
    logic [HUE_W:0] r;
    r = t;
    if (t >= {1'b0, HUE_TURN}) begin
      r = t - {1'b0, HUE_TURN};
    end
    return r[HUE_W-1:0];
  endfunction

  // ramp weight 0..256 of one channel at hue position t
  function automatic logic [FRAC_W-1:0] ramp_frac(input logic [HUE_W-1:0] t);
    logic [HUE_W-1:0] down;
    logic [FRAC_W-1:0] f;
    down = HUE_TWO_THIRDS - t;
    if (t < HUE_SIXTH) begin
      f = t[FRAC_W-1:0];
    end else if (t < HUE_HALF) begin
      f = FRAC_FULL;
    end else if (t < HUE_TWO_THIRDS) begin
      f = down[FRAC_W-1:0];
    end else begin
      f = '0;
    end
    return f;
  endfunction

endpackage

[rtl/hsl2rgb_prep.sv]
module hsl2rgb_prep #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FRAC_BITS
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           valid_i,
  output logic                                           ready_o,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]                  hue_i,
  input  logic [FRAC_BITS:0]                             saturation_i,
  input  logic [FRAC_BITS:0]                             lightness_i,
  output logic                                           valid_o,
  input  logic                                           ready_i,
  output logic [FRAC_BITS:0]                             saturation_o,
  output logic [FRAC_BITS:0]                             lightness_o,
  output logic                                           low_o,
  output logic [hsl2rgb_pkg::LANES*hsl2rgb_pkg::FRAC_W-1:0] frac_o
);

  localparam int unsigned N = FRAC_BITS + 1;
  localparam logic [N-1:0] ONE = N'(1) << FRAC_BITS;
  localparam int unsigned HW = hsl2rgb_pkg::HUE_W;
  localparam int unsigned FW = hsl2rgb_pkg::FRAC_W;

  logic [HW-1:0] hue_g, hue_r, hue_b;
  logic [N-1:0]  sat_c, light_c;
  logic          load;

  logic          valid_q;
  logic [N-1:0]  sat_q, light_q;
  logic          low_q;
  logic [3*FW-1:0] frac_q;

  assign hue_g   = hsl2rgb_pkg::wrap_hue({1'b0, hue_i});
  assign hue_r   = hsl2rgb_pkg::wrap_hue({1'b0, hue_g} + {1'b0, hsl2rgb_pkg::HUE_THIRD});
  assign hue_b   = hsl2rgb_pkg::wrap_hue({1'b0, hue_g} + {1'b0, hsl2rgb_pkg::HUE_TWO_THIRDS});
  assign sat_c   = (saturation_i > ONE) ? ONE : saturation_i;
  assign light_c = (lightness_i > ONE) ? ONE : lightness_i;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sat_q   <= sat_c;
      light_q <= light_c;
      low_q   <= (light_c[N-1:N-2] == 2'b00);
      frac_q  <= {hsl2rgb_pkg::ramp_frac(hue_b),
                  hsl2rgb_pkg::ramp_frac(hue_g),
                  hsl2rgb_pkg::ramp_frac(hue_r)};
    end
  end

  assign valid_o      = valid_q;
  assign saturation_o = sat_q;
  assign lightness_o  = light_q;
  assign low_o        = low_q;
  assign frac_o       = frac_q;

endmodule

[rtl/hsl2rgb_level.sv]
module hsl2rgb_level #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FRAC_BITS
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              valid_i,
  output logic                                              ready_o,
  input  logic [FRAC_BITS:0]                                saturation_i,
  input  logic [FRAC_BITS:0]                                lightness_i,
  input  logic                                              low_i,
  input  logic [hsl2rgb_pkg::LANES*hsl2rgb_pkg::FRAC_W-1:0] frac_i,
  output logic                                              valid_o,
  input  logic                                              ready_i,
  output logic [2*FRAC_BITS:0]                              p2_o,
  output logic [2*FRAC_BITS:0]                              m_o,
  output logic [hsl2rgb_pkg::LANES*hsl2rgb_pkg::FRAC_W-1:0] frac_o
);

  localparam int unsigned N   = FRAC_BITS + 1;
  localparam int unsigned P_W = 2 * FRAC_BITS + 1;
  localparam int unsigned F3  = hsl2rgb_pkg::LANES * hsl2rgb_pkg::FRAC_W;

  logic [2*N-1:0] prod;
  logic           ready_a;
  logic [P_W-1:0] m_d, p2_d;

  // product stage
  logic           valid_a_q;
  logic [P_W-1:0] ls_q;
  logic [N-1:0]   sat_a_q, light_a_q;
  logic           low_a_q;
  logic [F3-1:0]  frac_a_q;

  // level stage
  logic           valid_b_q;
  logic [P_W-1:0] p2_q, m_q;
  logic [F3-1:0]  frac_b_q;

  assign prod    = lightness_i * saturation_i;
  assign ready_o = !valid_a_q || ready_a;
  assign ready_a = !valid_b_q || ready_i;

  // half spread between q and p, which sit symmetric around the lightness
  assign m_d  = low_a_q ? ls_q : ({sat_a_q, {FRAC_BITS{1'b0}}} - ls_q);
  assign p2_d = {light_a_q, {FRAC_BITS{1'b0}}} - m_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_a_q <= valid_i;
      end
      if (ready_a) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ls_q      <= prod[P_W-1:0];
      sat_a_q   <= saturation_i;
      light_a_q <= lightness_i;
      low_a_q   <= low_i;
      frac_a_q  <= frac_i;
    end
    if (valid_a_q && ready_a) begin
      p2_q     <= p2_d;
      m_q      <= m_d;
      frac_b_q <= frac_a_q;
    end
  end

  assign valid_o = valid_b_q;
  assign p2_o    = p2_q;
  assign m_o     = m_q;
  assign frac_o  = frac_b_q;

endmodule

[rtl/hsl2rgb_chan.sv]
module hsl2rgb_chan #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FRAC_BITS
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              valid_i,
  output logic                                              ready_o,
  input  logic [2*FRAC_BITS:0]                              p2_i,
  input  logic [2*FRAC_BITS:0]                              m_i,
  input  logic [hsl2rgb_pkg::LANES*hsl2rgb_pkg::FRAC_W-1:0] frac_i,
  output logic                                              valid_o,
  input  logic                                              ready_i,
  output logic [hsl2rgb_pkg::LANES*hsl2rgb_pkg::CH_W-1:0]   rgb_o
);

  localparam int unsigned FW    = hsl2rgb_pkg::FRAC_W;
  localparam int unsigned CW    = hsl2rgb_pkg::CH_W;
  localparam int unsigned LANES = hsl2rgb_pkg::LANES;
  localparam int unsigned P_W   = 2 * FRAC_BITS + 1;
  localparam int unsigned M_W   = P_W + FW;
  localparam int unsigned V_W   = 2 * FRAC_BITS + 9;
  localparam int unsigned SHIFT = 2 * FRAC_BITS + 8;
  localparam int unsigned S_W   = V_W + 8;
  localparam logic [S_W-1:0] HALF = S_W'(1) << (SHIFT - 1);

  logic ready_a, ready_b;

  logic                 valid_a_q, valid_b_q, valid_c_q;
  logic [P_W-1:0]       p2_a_q;
  logic [M_W-1:0]       prod_q [LANES];
  logic [V_W-1:0]       lvl_q  [LANES];
  logic [LANES*CW-1:0]  rgb_q;

  assign ready_o = !valid_a_q || ready_a;
  assign ready_a = !valid_b_q || ready_b;
  assign ready_b = !valid_c_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_a_q <= valid_i;
      end
      if (ready_a) begin
        valid_b_q <= valid_a_q;
      end
      if (ready_b) begin
        valid_c_q <= valid_b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      p2_a_q <= p2_i;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [M_W-1:0] prod_d;
    logic [V_W-1:0] lvl_d;
    logic [S_W-1:0] scaled;

    assign prod_d = m_i * frac_i[k*FW +: FW];
    // level = p * 256 + (q - p) * ramp, with q - p = 2 * m
    assign lvl_d  = {p2_a_q, 8'd0} + {prod_q[k][V_W-2:0], 1'b0};
    // times 255, round half up
    assign scaled = {lvl_q[k], 8'd0} - {8'd0, lvl_q[k]} + HALF;

    always_ff @(posedge clk_i) begin
      if (valid_i && ready_o) begin
        prod_q[k] <= prod_d;
      end
      if (valid_a_q && ready_a) begin
        lvl_q[k] <= lvl_d;
      end
      if (valid_b_q && ready_b) begin
        rgb_q[k*CW +: CW] <= scaled[SHIFT +: CW];
      end
    end
  end

  assign valid_o = valid_c_q;
  assign rgb_o   = rgb_q;

endmodule

[rtl/hsl_to_rgb_converter_top.sv]
// channel   dir  tdata fields (low bit up)                       tuser/tlast
// s_axis    in   hue[10:0], saturation[FB:0], lightness[FB:0]      none
// m_axis    out  red[7:0], green[7:0], blue[7:0]                   none
//
// six register stages from s_axis to m_axis, one word per clock sustained while m_axis_tready stays high
// the last stage is the output register
// each stage holds its own valid bit and takes a word when empty or draining,
// so a stall on m_axis fills bubbles first and then backs up to s_axis_tready
// reset clears only the valid bits
module hsl_to_rgb_converter_top #(
  parameter int unsigned FRAC_BITS = hsl2rgb_pkg::FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // hue, saturation, lightness, zero fill
  input  logic [((hsl2rgb_pkg::HUE_W+2*(FRAC_BITS+1)+7)/8)*8-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // red, green, blue
  output logic [hsl2rgb_pkg::LANES*hsl2rgb_pkg::CH_W-1:0] m_axis_tdata
);

  localparam int unsigned HW = hsl2rgb_pkg::HUE_W;
  localparam int unsigned N  = FRAC_BITS + 1;
  localparam int unsigned P_W = 2 * FRAC_BITS + 1;
  localparam int unsigned F3 = hsl2rgb_pkg::LANES * hsl2rgb_pkg::FRAC_W;

  logic          prep_valid, prep_ready;
  logic [N-1:0]  prep_sat, prep_light;
  logic          prep_low;
  logic [F3-1:0] prep_frac;

  logic           lvl_valid, lvl_ready;
  logic [P_W-1:0] lvl_p2, lvl_m;
  logic [F3-1:0]  lvl_frac;

  hsl2rgb_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .hue_i        (s_axis_tdata[HW-1:0]),
    .saturation_i (s_axis_tdata[HW +: N]),
    .lightness_i  (s_axis_tdata[HW+N +: N]),
    .valid_o      (prep_valid),
    .ready_i      (prep_ready),
    .saturation_o (prep_sat),
    .lightness_o  (prep_light),
    .low_o        (prep_low),
    .frac_o       (prep_frac)
  );

  hsl2rgb_level #(
    .FRAC_BITS(FRAC_BITS)
  ) u_level (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (prep_valid),
    .ready_o      (prep_ready),
    .saturation_i (prep_sat),
    .lightness_i  (prep_light),
    .low_i        (prep_low),
    .frac_i       (prep_frac),
    .valid_o      (lvl_valid),
    .ready_i      (lvl_ready),
    .p2_o         (lvl_p2),
    .m_o          (lvl_m),
    .frac_o       (lvl_frac)
  );

  hsl2rgb_chan #(
    .FRAC_BITS(FRAC_BITS)
  ) u_chan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lvl_valid),
    .ready_o (lvl_ready),
    .p2_i    (lvl_p2),
    .m_i     (lvl_m),
    .frac_i  (lvl_frac),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rgb_o   (m_axis_tdata)
  );

endmodule
